>>> hdl/sisp_pkg.sv
// Shared constants and controller/datapath interface types for the insert position search.
`default_nettype none
package sisp_pkg;

   localparam int DEFAULT_DEPTH  = 1024;
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 11;

   // Request kind codes.
   localparam logic [0:0] KIND_LOAD  = 1'b0;
   localparam logic [0:0] KIND_QUERY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // append the request value to the array
      logic start;    // begin a search over the loaded elements
      logic probe;    // register the midpoint and read that element
      logic step;     // narrow the range with the element just read
      logic publish;  // move the search result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_open;  // left is still below right
      logic hit;         // element read equals the target
   } status_type;

endpackage
`default_nettype wire

>>> hdl/sisp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sisp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/sisp_datapath.sv
// Datapath: element store, element count, search bounds, comparator and result register.
`default_nettype none
module sisp_datapath #(
   parameter int DEPTH = sisp_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire sisp_pkg::cmd_type                       cmd,
   output sisp_pkg::status_type                         status,
   input  wire logic                                    req_restart,
   input  wire logic signed [sisp_pkg::VALUE_WIDTH-1:0] req_value,
   output logic        [sisp_pkg::POSITION_WIDTH-1:0]   rsp_position
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = sisp_pkg::POSITION_WIDTH;
   localparam int VAL_W  = sisp_pkg::VALUE_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [CNT_W-1:0]        right_ff, right_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic signed [VAL_W-1:0] target_ff, target_in;
   logic [POS_W-1:0]        position_ff, position_in;

   logic [CNT_W-1:0]        count_base;
   logic                    room;
   logic [CNT_W:0]          bound_sum;
   logic signed [VAL_W-1:0] probe_data;
   logic                    target_less;
   logic                    target_greater;
   logic [POS_W+CNT_W-1:0]  left_wide;

   // A restart empties the array before the element is appended.
   assign count_base = req_restart ? '0 : count_ff;
   assign room       = (count_base < DEPTH_CNT);

   assign bound_sum = {1'b0, left_ff} + {1'b0, right_ff};
   assign mid_in    = bound_sum[CNT_W:1];

   sisp_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.load && room),
      .wr_addr(count_base[ADDR_W-1:0]),
      .wr_data(req_value),
      .rd_en  (cmd.probe),
      .rd_addr(mid_in[ADDR_W-1:0]),
      .rd_data(probe_data)
   );

   assign target_less    = (target_ff < probe_data);
   assign target_greater = (probe_data < target_ff);

   assign status.range_open = (left_ff < right_ff);
   assign status.hit        = !target_less && !target_greater;

   assign left_wide = {{POS_W{1'b0}}, left_ff};

   always_comb begin
      count_in    = count_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      target_in   = target_ff;
      position_in = position_ff;
      if (cmd.load) begin
         count_in = room ? (count_base + CNT_W'(1)) : count_base;
      end
      if (cmd.start) begin
         left_in   = '0;
         right_in  = count_ff;
         target_in = req_value;
      end
      if (cmd.step) begin
         // On a match the midpoint becomes the reported position.
         priority if (target_less) begin
            right_in = mid_ff;
         end else if (target_greater) begin
            left_in = mid_ff + CNT_W'(1);
         end else begin
            left_in = mid_ff;
         end
      end
      if (cmd.publish) begin
         position_in = left_wide[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         count_ff <= count_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      target_ff   <= target_in;
      position_ff <= position_in;
      if (cmd.probe) begin
         mid_ff <= mid_in;
      end
   end

   assign rsp_position = position_ff;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("element count exceeds the array depth");

   a_bounds_ordered : assert property (@(posedge clock) disable iff (reset)
      left_ff <= right_ff)
      else $error("search left bound passed the right bound");

   a_mid_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.probe |=> (mid_ff >= left_ff) && (mid_ff < right_ff))
      else $error("probe index outside the open search range");

endmodule
`default_nettype wire

>>> hdl/sisp_ctrl.sv
// Controller: request handshake, search sequencing and the response valid flag.
`default_nettype none
module sisp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sisp_pkg::cmd_type         cmd,
   input  wire sisp_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PROBE   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_REPORT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  sisp_pkg::KIND_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  sisp_pkg::KIND_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = ST_PROBE;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (status.range_open) begin
               cmd.probe = 1'b1;
               state_in  = ST_COMPARE;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = status.hit ? ST_REPORT : ST_PROBE;
         end
         ST_REPORT: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_closed_range_reports : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) && !status.range_open |=> (state_ff == ST_REPORT))
      else $error("closed search range did not lead to a report");

   a_publish_sets_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented on the response port");

   a_response_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("response dropped before it was accepted");

endmodule
`default_nettype wire

>>> hdl/sorted_insert_position_search.sv
// Load request: no response; the next request may follow at once.
// Query request: k halving steps, k <= floor(log2(count)) + 1, each a RAM read state (PROBE)
// and a compare state (COMPARE), split by the registered read; a match ends the search early,
// and the result then passes through REPORT before the next request is accepted in IDLE.
// Loads are taken while a response waits for rsp_ready; a query result waits for that register.
// Synchronous reset empties the array and drops any pending response; the store is not cleared.
`default_nettype none
module sorted_insert_position_search #(
   parameter int DEPTH = sisp_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_kind,
   input  wire logic                                    req_restart,
   input  wire logic signed [sisp_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic        [sisp_pkg::POSITION_WIDTH-1:0]   rsp_position
);

   sisp_pkg::cmd_type    cmd;
   sisp_pkg::status_type status;

   sisp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_kind),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   sisp_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_restart (req_restart),
      .req_value   (req_value),
      .rsp_position(rsp_position)
   );

endmodule
`default_nettype wire
